[design/ahrt_pkg.sv]
// shared types and constants for the accelerating hold-repeat table
// no dependencies; imported by the interfaces and the top level
package ahrt_pkg;

    localparam int DEF_CHANNELS   = 8;
    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_KEY_BITS   = 8;

    localparam int OP_BITS   = 2;
    localparam int STEP_BITS = 4;

    // steps taken at half rate before a channel speeds up
    localparam logic [STEP_BITS-1:0] SLOW_STEPS = 4'd15;

    typedef enum logic [OP_BITS-1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ADD,
        ST_REM_RD,
        ST_REM_WR,
        ST_TICK,
        ST_FLUSH
    } state_t;

endpackage

[design/ahrt_cmd_if.sv]
// command channel of the hold-repeat table: valid/ready plus request fields
// depends on ahrt_pkg
interface ahrt_cmd_if import ahrt_pkg::*; #(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    operation;
    logic [KEY_BITS-1:0]   entry_key;
    logic [VALUE_BITS-1:0] start_value;
    logic [VALUE_BITS-1:0] upper_limit;
    logic [VALUE_BITS-1:0] lower_limit;
    logic                  count_up;

    modport source (
        output valid, operation, entry_key, start_value, upper_limit, lower_limit, count_up,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_key, start_value, upper_limit, lower_limit, count_up,
        output ready
    );
endinterface

// result channel: one transaction per channel step
interface ahrt_result_if import ahrt_pkg::*; #(
    parameter int KEY_BITS   = DEF_KEY_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
);
    logic                  valid;
    logic                  ready;
    logic [KEY_BITS-1:0]   out_key;
    logic [VALUE_BITS-1:0] new_value;
    logic                  last;

    modport source (
        output valid, out_key, new_value, last,
        input  ready
    );
    modport sink (
        input  valid, out_key, new_value, last,
        output ready
    );
endinterface

[design/accelerating_hold_repeat_table.sv]
// Table of up to CHANNELS accelerating auto-repeat channels, all entries held
// in one synchronous memory with a registered read. A command transaction is
// taken only while the table is idle. Start, unless the table is full, and stop
// scan the keys at one entry per cycle; a key that is found is removed by moving
// the tail entry into its slot. A tick streams the entries through a
// read-modify-write loop at one entry per cycle, held back only while the
// result channel holds off. The result register lets the next command be
// taken while the final result of a tick still waits.
// depends on ahrt_pkg, ahrt_cmd_if and ahrt_result_if
module accelerating_hold_repeat_table import ahrt_pkg::*; #(
    parameter int CHANNELS   = DEF_CHANNELS,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int KEY_BITS   = DEF_KEY_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    ahrt_cmd_if.sink      cmd,
    ahrt_result_if.source result
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] max;
        logic [VALUE_BITS-1:0] min;
        logic                  up;
        logic [STEP_BITS-1:0]  step;
        logic                  half;
    } entry_t;

    entry_t mem [CHANNELS];
    entry_t rd_data;
    entry_t wr_data;
    entry_t upd;
    logic   rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             dvld_reg, dvld_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [KEY_BITS-1:0]   pend_key_reg, pend_key_next;
    logic [VALUE_BITS-1:0] pend_val_reg, pend_val_next;
    logic             out_vld_reg, out_vld_next;
    logic [KEY_BITS-1:0]   out_key_reg, out_key_next;
    logic [VALUE_BITS-1:0] out_val_reg, out_val_next;
    logic             out_last_reg, out_last_next;

    // latched command fields
    logic [OP_BITS-1:0]    op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] init_reg, max_reg, min_reg;
    logic                  up_reg;

    logic accept, more, match, e_step, out_free, tick_stall, push, push_last;
    logic [CNT_W-1:0] tail_cnt;
    logic [IDX_W-1:0] tail_idx;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign more      = (rd_idx_reg < count_reg);
    assign match     = dvld_reg && (rd_data.key == key_reg);
    assign tail_cnt  = count_reg - CNT_W'(1);
    assign tail_idx  = tail_cnt[IDX_W-1:0];
    assign out_free  = !out_vld_reg || result.ready;

    // a channel steps every tick once saturated, else on every second tick
    assign e_step     = (rd_data.step == SLOW_STEPS) || rd_data.half;
    assign tick_stall = dvld_reg && e_step && pend_vld_reg && !out_free;

    always_comb
    begin
        upd = rd_data;
        if (!e_step)
        begin
            upd.half = 1'b1;
        end
        else
        begin
            upd.half = 1'b0;
            if (rd_data.step != SLOW_STEPS)
            begin
                upd.step = rd_data.step + STEP_BITS'(1);
            end
            if (rd_data.up)
            begin
                if (rd_data.value < rd_data.max)
                begin
                    upd.value = rd_data.value + VALUE_BITS'(1);
                end
            end
            else if (rd_data.value > rd_data.min)
            begin
                upd.value = rd_data.value - VALUE_BITS'(1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.operation)
                        OP_START:
                        begin
                            if (count_reg != CNT_W'(CHANNELS))
                            begin
                                state_next = ST_SEARCH;
                            end
                        end
                        OP_STOP:  state_next = ST_SEARCH;
                        OP_TICK:  state_next = ST_TICK;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = ST_REM_RD;
                end
                else if (!more)
                begin
                    state_next = (op_reg == OP_START) ? ST_ADD : ST_IDLE;
                end
            end
            ST_ADD:    state_next = ST_IDLE;
            ST_REM_RD: state_next = ST_REM_WR;
            ST_REM_WR: state_next = ST_IDLE;
            ST_TICK:
            begin
                if (!tick_stall && !more)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next    = count_reg;
        rd_idx_next   = rd_idx_reg;
        wr_idx_next   = wr_idx_reg;
        slot_next     = slot_reg;
        dvld_next     = dvld_reg;
        pend_vld_next = pend_vld_reg;
        pend_key_next = pend_key_reg;
        pend_val_next = pend_val_reg;
        rd_en     = 1'b0;
        rd_addr   = rd_idx_reg[IDX_W-1:0];
        wr_en     = 1'b0;
        wr_addr   = wr_idx_reg;
        wr_data   = upd;
        push      = 1'b0;
        push_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                dvld_next   = 1'b0;
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    slot_next = wr_idx_reg;
                    dvld_next = 1'b0;
                end
                else if (more)
                begin
                    rd_en       = 1'b1;
                    wr_idx_next = rd_idx_reg[IDX_W-1:0];
                    dvld_next   = 1'b1;
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                else
                begin
                    dvld_next = 1'b0;
                end
            end
            ST_ADD:
            begin
                wr_en         = 1'b1;
                wr_addr       = count_reg[IDX_W-1:0];
                wr_data.key   = key_reg;
                wr_data.value = init_reg;
                wr_data.max   = max_reg;
                wr_data.min   = min_reg;
                wr_data.up    = up_reg;
                wr_data.step  = '0;
                wr_data.half  = 1'b0;
                count_next    = count_reg + CNT_W'(1);
            end
            ST_REM_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = tail_idx;
            end
            ST_REM_WR:
            begin
                // move the tail entry into the hole
                if (slot_reg != tail_idx)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_reg;
                    wr_data = rd_data;
                end
                count_next = tail_cnt;
            end
            ST_TICK:
            begin
                if (!tick_stall)
                begin
                    if (dvld_reg)
                    begin
                        wr_en = 1'b1;
                        if (e_step)
                        begin
                            // hold each result back one step so the last flag is known
                            push          = pend_vld_reg;
                            pend_vld_next = 1'b1;
                            pend_key_next = rd_data.key;
                            pend_val_next = upd.value;
                        end
                    end
                    if (more)
                    begin
                        rd_en       = 1'b1;
                        wr_idx_next = rd_idx_reg[IDX_W-1:0];
                        dvld_next   = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dvld_next = 1'b0;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pend_vld_reg && out_free)
                begin
                    push          = 1'b1;
                    push_last     = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                dvld_next = 1'b0;
            end
        endcase
    end

    // result register
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_key_next  = out_key_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        if (push)
        begin
            out_vld_next  = 1'b1;
            out_key_next  = pend_key_reg;
            out_val_next  = pend_val_reg;
            out_last_next = push_last;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    assign result.valid     = out_vld_reg;
    assign result.out_key   = out_key_reg;
    assign result.new_value = out_val_reg;
    assign result.last      = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            rd_idx_reg   <= '0;
            wr_idx_reg   <= '0;
            slot_reg     <= '0;
            dvld_reg     <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_idx_reg   <= rd_idx_next;
            wr_idx_reg   <= wr_idx_next;
            slot_reg     <= slot_next;
            dvld_reg     <= dvld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_key_reg <= pend_key_next;
        pend_val_reg <= pend_val_next;
        out_key_reg  <= out_key_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        if (accept)
        begin
            op_reg   <= cmd.operation;
            key_reg  <= cmd.entry_key;
            init_reg <= cmd.start_value;
            max_reg  <= cmd.upper_limit;
            min_reg  <= cmd.lower_limit;
            up_reg   <= cmd.count_up;
        end
    end

endmodule

[verif/accelerating_hold_repeat_table_tb.sv]
`timescale 1ns / 1ps
// testbench for accelerating_hold_repeat_table: directed rows then random commands,
// every step result checked in order, against the row's own expectation or a cycle-free model of the channel table
// depends on ahrt_pkg, ahrt_cmd_if, ahrt_result_if and the block itself
module accelerating_hold_repeat_table_tb;
    import ahrt_pkg::*;

    localparam int CH = DEF_CHANNELS;
    localparam int VB = DEF_VALUE_BITS;
    localparam int KB = DEF_KEY_BITS;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam logic [VB-1:0]      VTOP      = '1;

    localparam int RANDOM_ITEMS = 455;
    localparam int QUIET_ITEMS  = 60;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 150;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 30;

    localparam logic [KB-1:0] KEY_POOL [12] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A, 8'hA5,
                                               8'h3C, 8'hC3, 8'h7F, 8'hFE, 8'h10, 8'h42};

    typedef struct packed {
        logic [KB-1:0] key;
        logic [VB-1:0] value;
        logic          last;
    } step_t;

    typedef struct {
        logic [OP_BITS-1:0] op;
        logic [KB-1:0]      key;
        logic [VB-1:0]      value;
        logic [VB-1:0]      hi;
        logic [VB-1:0]      lo;
        logic               up;
        logic               typed;      // expectation written into the row
        int                 typed_n;    // 0 or 1 steps
        logic [KB-1:0]      typed_key;
        logic [VB-1:0]      typed_value;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    ahrt_cmd_if    cmd_if ();
    ahrt_result_if res_if ();

    accelerating_hold_repeat_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if)
    );

    // model of the channel table
    logic [KB-1:0]        tbl_key   [CH];
    logic [VB-1:0]        tbl_val   [CH];
    logic [VB-1:0]        tbl_hi    [CH];
    logic [VB-1:0]        tbl_lo    [CH];
    logic                 tbl_up    [CH];
    logic [STEP_BITS-1:0] tbl_steps [CH];
    logic                 tbl_half  [CH];
    int                   live = 0;

    step_t    burst [CH];
    int       burst_len;
    step_t    pending_steps [$];
    cmd_row_t offered;
    cmd_row_t script [$];

    int  applied       = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  tick_count    = 0;
    int  start_count   = 0;
    int  stop_count    = 0;
    int  unused_count  = 0;
    int  fast_steps    = 0;
    int  full_refusals = 0;
    bit  idle_on       = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int find_slot(input logic [KB-1:0] key);
        for (int i = 0; i < live; i++)
            if (tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // the tail entry fills the hole
    function automatic void drop_slot(input int slot);
        int tail;
        tail = live - 1;
        tbl_key[slot]   = tbl_key[tail];
        tbl_val[slot]   = tbl_val[tail];
        tbl_hi[slot]    = tbl_hi[tail];
        tbl_lo[slot]    = tbl_lo[tail];
        tbl_up[slot]    = tbl_up[tail];
        tbl_steps[slot] = tbl_steps[tail];
        tbl_half[slot]  = tbl_half[tail];
        live = tail;
    endfunction

    function automatic void advance_table(input cmd_row_t r);
        int slot;
        burst_len = 0;
        case (r.op)
            OP_START:
            begin
                start_count++;
                if (live == CH)
                    full_refusals++;
                else
                begin
                    slot = find_slot(r.key);
                    if (slot >= 0)
                        drop_slot(slot);
                    else
                    begin
                        tbl_key[live]   = r.key;
                        tbl_val[live]   = r.value;
                        tbl_hi[live]    = r.hi;
                        tbl_lo[live]    = r.lo;
                        tbl_up[live]    = r.up;
                        tbl_steps[live] = '0;
                        tbl_half[live]  = 1'b0;
                        live++;
                    end
                    applied++;
                end
            end
            OP_STOP:
            begin
                stop_count++;
                slot = find_slot(r.key);
                if (slot >= 0)
                begin
                    drop_slot(slot);
                    applied++;
                end
            end
            OP_TICK:
            begin
                tick_count++;
                if (live > 0)
                    applied++;
                for (int i = 0; i < live; i++)
                begin
                    if (tbl_steps[i] < SLOW_STEPS && !tbl_half[i])
                        tbl_half[i] = 1'b1;
                    else
                    begin
                        tbl_half[i] = 1'b0;
                        if (tbl_steps[i] < SLOW_STEPS)
                            tbl_steps[i]++;
                        else
                            fast_steps++;
                        if (tbl_up[i])
                        begin
                            if (tbl_val[i] < tbl_hi[i])
                                tbl_val[i]++;
                        end
                        else if (tbl_val[i] > tbl_lo[i])
                            tbl_val[i]--;
                        burst[burst_len] = '{tbl_key[i], tbl_val[i], 1'b0};
                        burst_len++;
                    end
                end
                if (burst_len > 0)
                    burst[burst_len-1].last = 1'b1;
            end
            default:
                unused_count++;
        endcase
    endfunction

    function automatic void flag_mismatch(input string what, input step_t want,
                                          input step_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected key %02h value %08h last %0b, %s %02h value %08h last %0b",
                     $realtime, what, want.key, want.value, want.last,
                     "got key", got.key, got.value, got.last);
    endfunction

    // results are checked before the new command is modeled, so a result and a
    // command taken at the same edge are kept in order
    always @(posedge clk)
    begin : check_and_predict
        step_t got;
        step_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                results_seen++;
                got = '{res_if.out_key, res_if.new_value, res_if.last};
                if (pending_steps.size() == 0)
                    flag_mismatch("unexpected result", '0, got);
                else
                begin
                    want = pending_steps.pop_front();
                    if (want.key !== got.key || want.value !== got.value
                        || want.last !== got.last)
                        flag_mismatch("result mismatch", want, got);
                end
            end
            if (cmd_if.valid && cmd_if.ready)
            begin
                advance_table(offered);
                if (offered.typed)
                begin
                    if (offered.typed_n > 0)
                        pending_steps.push_back(step_t'{offered.typed_key,
                                                        offered.typed_value, 1'b1});
                end
                else
                    for (int i = 0; i < burst_len; i++)
                        pending_steps.push_back(burst[i]);
            end
        end
    end

    initial
    begin : result_sink
        int  stall;
        bit  held_off;
        stall    = 0;
        held_off = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            // one long hold-off so the table backs up into the command side
            if (!held_off && results_seen >= HOLD_AFTER && cmd_if.valid)
            begin
                held_off = 1'b1;
                stall    = LONG_HOLD;
            end
            else if (stall == 0 && idle_on && $urandom_range(0, 7) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                stall--;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("no transaction for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic offer(input cmd_row_t r);
        cmd_if.valid       <= 1'b1;
        cmd_if.operation   <= r.op;
        cmd_if.entry_key   <= r.key;
        cmd_if.start_value <= r.value;
        cmd_if.upper_limit <= r.hi;
        cmd_if.lower_limit <= r.lo;
        cmd_if.count_up    <= r.up;
        offered            <= r;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic pause_until_drained();
        cmd_if.valid <= 1'b0;
        // let the checker queue the steps of the command taken at this edge
        @(posedge clk);
        while (pending_steps.size() != 0)
            @(posedge clk);
    endtask

    function automatic cmd_row_t random_row(input bit steady);
        cmd_row_t r;
        int       pick;
        logic [VB-1:0] span;
        r = '{default: '0};
        pick = $urandom_range(0, 99);
        if (steady)
        begin
            if (pick < 90)      r.op = OP_TICK;
            else if (pick < 95) r.op = OP_START;
            else                r.op = OP_STOP;
        end
        else
        begin
            if (pick < 50)      r.op = OP_TICK;
            else if (pick < 75) r.op = OP_START;
            else if (pick < 93) r.op = OP_STOP;
            else                r.op = OP_UNUSED;
        end
        if ($urandom_range(0, 6) == 0)
            r.key = KB'($urandom);
        else
            r.key = KEY_POOL[$urandom_range(0, 11)];
        r.up    = 1'($urandom_range(0, 1));
        r.value = VB'($urandom);
        span    = VB'($urandom_range(0, 6));
        case ($urandom_range(0, 3))
            0:
            begin
                r.hi = VB'($urandom);
                r.lo = VB'($urandom);
            end
            // limits a few steps away, so clamping is reached
            1:
            begin
                r.hi = r.value + span;
                r.lo = r.value - span;
            end
            2:
            begin
                r.value = $urandom_range(0, 1) ? VTOP : '0;
                r.hi    = $urandom_range(0, 1) ? VTOP : VB'($urandom);
                r.lo    = $urandom_range(0, 1) ? '0 : VB'($urandom);
            end
            // value already outside both limits
            default:
            begin
                r.hi = r.value - span - 1'b1;
                r.lo = r.value + span + 1'b1;
            end
        endcase
        return r;
    endfunction

    initial
    begin : stimulus
        int  sent;
        int  phase_left;
        bit  steady;
        bit  paused;
        rst_n              = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.operation   = '0;
        cmd_if.entry_key   = '0;
        cmd_if.start_value = '0;
        cmd_if.upper_limit = '0;
        cmd_if.lower_limit = '0;
        cmd_if.count_up    = 1'b0;
        offered            = '{default: '0};
        sent               = 0;
        phase_left         = 0;
        steady             = 1'b0;
        paused             = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, absent key, unused code
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_STOP,   8'hFF, VTOP, VTOP, VTOP, 1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_UNUSED, 8'hFF, VTOP, VTOP, VTOP, 1'b1, 1'b1, 0, 8'h00, '0});
        // first channel: slow phase steps on every second tick
        script.push_back('{OP_START,  8'h00, '0,   VTOP, '0,   1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b1, 1, 8'h00, 32'd1});
        // second channel already at its upper limit
        script.push_back('{OP_START,  8'hFF, VTOP, VTOP, '0,   1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b0, 0, 8'h00, '0});
        // start of a present key removes it, tail moves into slot 0
        script.push_back('{OP_START,  8'h00, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'hA5, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'h5A, 32'd5, 32'd3, '0, 1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'h3C, 32'd2, VTOP, 32'd9, 1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'hC3, VTOP - 1'b1, VTOP, '0, 1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'h01, 32'd7, 32'd8, 32'd6, 1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'h80, VTOP, VTOP, VTOP, 1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'h7F, 32'd1, 32'd10, 32'd1, 1'b0, 1'b1, 0, 8'h00, '0});
        // full table refuses new and present keys alike
        script.push_back('{OP_START,  8'h11, '0,   VTOP, '0,   1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_START,  8'hFF, '0,   VTOP, '0,   1'b1, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b0, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b0, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b0, 0, 8'h00, '0});
        script.push_back('{OP_STOP,   8'h5A, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_STOP,   8'h7F, '0,   '0,   '0,   1'b0, 1'b1, 0, 8'h00, '0});
        script.push_back('{OP_TICK,   8'h00, '0,   '0,   '0,   1'b0, 1'b0, 0, 8'h00, '0});
        foreach (script[i])
            offer(script[i]);
        pause_until_drained();

        // random phases: busy mixes of all commands, or steady runs of ticks
        // that carry channels past the slow phase
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                steady     = ($urandom_range(0, 2) == 0);
                phase_left = $urandom_range(20, 60);
                idle_on    = ($urandom_range(0, 3) != 0);
            end
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            if (!paused && sent >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                pause_until_drained();
            end
            offer(random_row(steady));
            sent++;
            phase_left--;
        end
        pause_until_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_steps.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_steps.size());
            mismatches += pending_steps.size();
        end

        $display("commands: %0d ticks, %0d starts (%0d refused on a full table), %0d stops",
                 tick_count, start_count, full_refusals, stop_count);
        $display("          %0d unused codes, %0d that changed the table or stepped",
                 unused_count, applied);
        $display("steps checked: %0d, of which %0d at full speed; mismatches: %0d",
                 results_seen, fast_steps, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
